[rtl/assert_macros.svh]
// Shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif

`endif

[rtl/rkd_pkg.sv]
package rkd_pkg;

    localparam int PRIME_BITS = 16;
    localparam logic [15:0] PMASK = 16'((32'd1 << PRIME_BITS) - 32'd1);
    localparam int ARITH_STEPS = 32;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_NOT_PRIME   = 2'd1;
    localparam logic [1:0] ST_EXP_INVALID = 2'd2;

    localparam logic [1:0] REG_PRIME_P    = 2'd0;
    localparam logic [1:0] REG_PRIME_Q    = 2'd1;
    localparam logic [1:0] REG_PUBLIC_EXP = 2'd2;

    typedef enum logic {
        OP_DIV  = 1'b0,
        OP_MMUL = 1'b1
    } arith_op_t;

    typedef struct packed {
        logic      start;
        arith_op_t op;
    } arith_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } arith_rsp_t;

endpackage

[rtl/rkd_req_if.sv]
interface rkd_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [31:0] message_value;

    modport source (output valid, output req_type, output message_value, input ready);
    modport sink (input valid, input req_type, input message_value, output ready);
endinterface

[rtl/rkd_rsp_if.sv]
interface rkd_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] result_value;
    logic [1:0]  status;

    modport source (output valid, output result_value, output status, input ready);
    modport sink (input valid, input result_value, input status, output ready);
endinterface

[rtl/rkd_arith.sv]
module rkd_arith (
    input  logic               clk,
    input  logic               rst_n,
    input  rkd_pkg::arith_req_t arq,
    input  logic [31:0]        opa,
    input  logic [31:0]        opb,
    input  logic [31:0]        opm,
    output rkd_pkg::arith_rsp_t ars,
    output logic [31:0]        res_q,
    output logic [31:0]        res_r
);
    import rkd_pkg::*;

    localparam int CW = $clog2(ARITH_STEPS);

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    arith_op_t       op_reg, op_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [31:0]     sh_reg, sh_next;
    logic [31:0]     acc_reg, acc_next;
    logic [31:0]     a_reg, a_next;
    logic [31:0]     m_reg, m_next;
    logic [32:0]     div_t;
    logic [33:0]     mm_t;
    logic [33:0]     two_m;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        sh_next   = sh_reg;
        acc_next  = acc_reg;
        a_next    = a_reg;
        m_next    = m_reg;
        div_t     = {acc_reg, sh_reg[31]};
        mm_t      = {1'b0, acc_reg, 1'b0} + (sh_reg[31] ? {2'b00, a_reg} : 34'd0);
        two_m     = {1'b0, m_reg, 1'b0};
        if (arq.start && !busy_reg)
        begin
            busy_next = 1'b1;
            op_next   = arq.op;
            cnt_next  = '0;
            acc_next  = '0;
            if (arq.op == OP_DIV)
            begin
                sh_next = opa;
                a_next  = opb;
            end
            else
            begin
                sh_next = opb;
                a_next  = opa;
            end
            m_next = opm;
        end
        else if (busy_reg)
        begin
            if (op_reg == OP_DIV)
            begin
                if (div_t >= {1'b0, a_reg})
                begin
                    acc_next = 32'(div_t - {1'b0, a_reg});
                    sh_next  = {sh_reg[30:0], 1'b1};
                end
                else
                begin
                    acc_next = div_t[31:0];
                    sh_next  = {sh_reg[30:0], 1'b0};
                end
            end
            else
            begin
                sh_next = {sh_reg[30:0], 1'b0};
                if (mm_t >= two_m)
                    acc_next = 32'(mm_t - two_m);
                else if (mm_t >= {2'b00, m_reg})
                    acc_next = 32'(mm_t - {2'b00, m_reg});
                else
                    acc_next = mm_t[31:0];
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(ARITH_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= OP_DIV;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            op_reg   <= op_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg  <= sh_next;
        acc_reg <= acc_next;
        a_reg   <= a_next;
        m_reg   <= m_next;
    end

    assign ars.busy = busy_reg;
    assign ars.done = done_reg;
    assign res_q    = sh_reg;
    assign res_r    = acc_reg;

endmodule

[rtl/rsa_key_derive_and_modexp_top.sv]
// Channel  Direction  Payload
// req      in         req_type, message_value
// rsp      out        result_value, status
// cfg      in         cfg_we, cfg_index, cfg_data (0 prime_p, 1 prime_q, 2 public_exp)
// One item at a time; a new item is taken only when the sequencer is idle.
// Each serial divide or modular multiply runs on the shared unit.
// Per item: trial division, Euclid rounds of one divide and one modular
// multiply each, and modular multiplies (at most 64) of the exponentiation.
// Reset returns to idle with no output valid and zeroes the config registers.
// A finished result waits in the output register while the next item is taken.
`include "assert_macros.svh"

module rsa_key_derive_and_modexp_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    rkd_req_if.sink     req,
    rkd_rsp_if.source   rsp
);
    import rkd_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_PRIME   = 9'b000000010,
        S_KEY     = 9'b000000100,
        S_EUC_DIV = 9'b000001000,
        S_EUC_MUL = 9'b000010000,
        S_REDUCE  = 9'b000100000,
        S_POW_MUL = 9'b001000000,
        S_POW_SQR = 9'b010000000,
        S_DONE    = 9'b100000000
    } state_t;

    state_t      state_reg, state_next;
    logic        wait_reg, wait_next;
    logic        sel_reg, sel_next;
    logic [8:0]  i_reg, i_next;
    logic [15:0] p_reg, q_reg;
    logic [31:0] e_reg;
    logic        rtype_reg, rtype_next;
    logic [31:0] msg_reg, msg_next;
    logic [31:0] n_reg, n_next;
    logic [31:0] t_reg, t_next;
    logic [31:0] r0_reg, r0_next, r1_reg, r1_next;
    logic [31:0] s0_reg, s0_next, s1_reg, s1_next;
    logic [31:0] qd_reg, qd_next;
    logic [31:0] exp_reg, exp_next;
    logic [31:0] base_reg, base_next;
    logic [31:0] res_reg, res_next;
    logic [1:0]  stat_reg, stat_next;
    logic        ovalid_reg, ovalid_next;
    logic [31:0] oval_reg, oval_next;
    logic [1:0]  ostat_reg, ostat_next;

    arith_req_t  arq;
    arith_rsp_t  ars;
    logic [31:0] opa, opb, opm, res_q, res_r;
    logic [15:0] p_val, q_val, m_val;
    logic [17:0] ii;
    logic [31:0] tk;

    rkd_arith u_arith (
        .clk   (clk),
        .rst_n (rst_n),
        .arq   (arq),
        .opa   (opa),
        .opb   (opb),
        .opm   (opm),
        .ars   (ars),
        .res_q (res_q),
        .res_r (res_r)
    );

    assign p_val = p_reg & PMASK;
    assign q_val = q_reg & PMASK;
    assign m_val = sel_reg ? q_val : p_val;
    assign ii    = 18'(i_reg * i_reg);
    assign tk    = 32'((p_val - 16'd1) * (q_val - 16'd1));
    assign req.ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        wait_next   = wait_reg;
        sel_next    = sel_reg;
        i_next      = i_reg;
        rtype_next  = rtype_reg;
        msg_next    = msg_reg;
        n_next      = n_reg;
        t_next      = t_reg;
        r0_next     = r0_reg;
        r1_next     = r1_reg;
        s0_next     = s0_reg;
        s1_next     = s1_reg;
        qd_next     = qd_reg;
        exp_next    = exp_reg;
        base_next   = base_reg;
        res_next    = res_reg;
        stat_next   = stat_reg;
        ovalid_next = ovalid_reg;
        oval_next   = oval_reg;
        ostat_next  = ostat_reg;
        arq.start   = 1'b0;
        arq.op      = OP_DIV;
        opa         = '0;
        opb         = '0;
        opm         = '0;

        if (ovalid_reg && rsp.ready)
            ovalid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    rtype_next = req.req_type;
                    msg_next   = req.message_value;
                    sel_next   = 1'b0;
                    i_next     = 9'd2;
                    wait_next  = 1'b0;
                    state_next = S_PRIME;
                end
            end
            S_PRIME:
            begin
                opa = {16'd0, m_val};
                opb = {23'd0, i_reg};
                if (!wait_reg)
                begin
                    if (m_val < 16'd2)
                    begin
                        res_next   = '0;
                        stat_next  = ST_NOT_PRIME;
                        state_next = S_DONE;
                    end
                    else if (ii > {2'b00, m_val})
                    begin
                        if (!sel_reg)
                        begin
                            sel_next = 1'b1;
                            i_next   = 9'd2;
                        end
                        else
                            state_next = S_KEY;
                    end
                    else
                    begin
                        arq.start = 1'b1;
                        wait_next = 1'b1;
                    end
                end
                else if (ars.done)
                begin
                    wait_next = 1'b0;
                    if (res_r == '0)
                    begin
                        res_next   = '0;
                        stat_next  = ST_NOT_PRIME;
                        state_next = S_DONE;
                    end
                    else
                        i_next = i_reg + 9'd1;
                end
            end
            S_KEY:
            begin
                n_next = 32'(p_val * q_val);
                t_next = tk;
                if (tk < 32'd2 || e_reg == '0 || e_reg > tk)
                begin
                    res_next   = '0;
                    stat_next  = ST_EXP_INVALID;
                    state_next = S_DONE;
                end
                else
                begin
                    r0_next    = tk;
                    r1_next    = (e_reg == tk) ? '0 : e_reg;
                    s0_next    = '0;
                    s1_next    = 32'd1;
                    state_next = S_EUC_DIV;
                end
            end
            S_EUC_DIV:
            begin
                opa = r0_reg;
                opb = r1_reg;
                if (!wait_reg)
                begin
                    if (r1_reg == '0)
                    begin
                        if (r0_reg != 32'd1)
                        begin
                            res_next   = '0;
                            stat_next  = ST_EXP_INVALID;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            exp_next   = rtype_reg ? s0_reg : e_reg;
                            state_next = S_REDUCE;
                        end
                    end
                    else
                    begin
                        arq.start = 1'b1;
                        wait_next = 1'b1;
                    end
                end
                else if (ars.done)
                begin
                    wait_next  = 1'b0;
                    qd_next    = (res_q == t_reg) ? '0 : res_q;
                    r0_next    = r1_reg;
                    r1_next    = res_r;
                    state_next = S_EUC_MUL;
                end
            end
            S_EUC_MUL:
            begin
                arq.op = OP_MMUL;
                opa    = qd_reg;
                opb    = s1_reg;
                opm    = t_reg;
                if (!wait_reg)
                begin
                    arq.start = 1'b1;
                    wait_next = 1'b1;
                end
                else if (ars.done)
                begin
                    wait_next = 1'b0;
                    s0_next   = s1_reg;
                    if (s0_reg >= res_r)
                        s1_next = s0_reg - res_r;
                    else
                        s1_next = (t_reg - res_r) + s0_reg;
                    state_next = S_EUC_DIV;
                end
            end
            S_REDUCE:
            begin
                opa = msg_reg;
                opb = n_reg;
                if (!wait_reg)
                begin
                    arq.start = 1'b1;
                    wait_next = 1'b1;
                end
                else if (ars.done)
                begin
                    wait_next  = 1'b0;
                    base_next  = res_r;
                    res_next   = 32'd1;
                    state_next = S_POW_MUL;
                end
            end
            S_POW_MUL:
            begin
                arq.op = OP_MMUL;
                opa    = res_reg;
                opb    = base_reg;
                opm    = n_reg;
                if (!wait_reg)
                begin
                    if (exp_reg == '0)
                    begin
                        stat_next  = ST_OK;
                        state_next = S_DONE;
                    end
                    else if (!exp_reg[0])
                        state_next = S_POW_SQR;
                    else
                    begin
                        arq.start = 1'b1;
                        wait_next = 1'b1;
                    end
                end
                else if (ars.done)
                begin
                    wait_next  = 1'b0;
                    res_next   = res_r;
                    state_next = S_POW_SQR;
                end
            end
            S_POW_SQR:
            begin
                arq.op = OP_MMUL;
                opa    = base_reg;
                opb    = base_reg;
                opm    = n_reg;
                if (!wait_reg)
                begin
                    arq.start = 1'b1;
                    wait_next = 1'b1;
                end
                else if (ars.done)
                begin
                    wait_next  = 1'b0;
                    base_next  = res_r;
                    exp_next   = {1'b0, exp_reg[31:1]};
                    state_next = S_POW_MUL;
                end
            end
            S_DONE:
            begin
                if (!ovalid_reg || rsp.ready)
                begin
                    ovalid_next = 1'b1;
                    oval_next   = res_reg;
                    ostat_next  = stat_reg;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
                wait_next  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            wait_reg   <= 1'b0;
            sel_reg    <= 1'b0;
            ovalid_reg <= 1'b0;
            p_reg      <= '0;
            q_reg      <= '0;
            e_reg      <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            wait_reg   <= wait_next;
            sel_reg    <= sel_next;
            ovalid_reg <= ovalid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_PRIME_P:    p_reg <= cfg_data[15:0];
                    REG_PRIME_Q:    q_reg <= cfg_data[15:0];
                    REG_PUBLIC_EXP: e_reg <= cfg_data;
                    default:        ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg     <= i_next;
        rtype_reg <= rtype_next;
        msg_reg   <= msg_next;
        n_reg     <= n_next;
        t_reg     <= t_next;
        r0_reg    <= r0_next;
        r1_reg    <= r1_next;
        s0_reg    <= s0_next;
        s1_reg    <= s1_next;
        qd_reg    <= qd_next;
        exp_reg   <= exp_next;
        base_reg  <= base_next;
        res_reg   <= res_next;
        stat_reg  <= stat_next;
        oval_reg  <= oval_next;
        ostat_reg <= ostat_next;
    end

    assign rsp.valid        = ovalid_reg;
    assign rsp.result_value = oval_reg;
    assign rsp.status       = ostat_reg;

    `ASSERT_IMPLIES(a_start_free, clk, rst_n, arq.start, !ars.busy)
    `ASSERT_IMPLIES(a_err_zero, clk, rst_n, rsp.valid && rsp.status != ST_OK, rsp.result_value == '0)
    `ASSERT_NEXT(a_leave_idle, clk, rst_n, req.valid && req.ready, state_reg == S_PRIME)
    `ASSERT_IMPLIES(a_done_waiting, clk, rst_n, ars.done, wait_reg)

endmodule
